### src/ppg_apd_pkg.sv
package ppg_apd_pkg;

    // Crest detector phase
    typedef enum logic [1:0] {
        PH_ARMED  = 2'd0,
        PH_RISING = 2'd1,
        PH_BLANK  = 2'd2
    } t_phase;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_CONTACT_LEVEL    = 3'd0,
        REG_REFRACTORY_MS    = 3'd1,
        REG_MIN_INTERVAL_MS  = 3'd2,
        REG_MAX_INTERVAL_MS  = 3'd3,
        REG_MAX_JUMP_MS      = 3'd4,
        REG_SETTLE_MS        = 3'd5,
        REG_LOW_PERFUSION_MS = 3'd6,
        REG_MIN_THR_OFFSET   = 3'd7
    } t_reg_idx;

    // Contact quality codes
    typedef enum logic [1:0] {
        Q_NO_CONTACT    = 2'd0,
        Q_LOW_PERFUSION = 2'd1,
        Q_ACQUIRING     = 2'd2,
        Q_TRACKING      = 2'd3
    } t_quality;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int LEVEL_W  = 18;  // contact_level, min_threshold_offset
    localparam int MS_W     = 16;  // millisecond registers and interval
    localparam int COUNT_W  = 4;
    localparam int STREAK_W = 2;
    localparam int FALL_W   = 2;

    localparam logic [LEVEL_W-1:0] CONTACT_LEVEL_RST  = 18'd1500;
    localparam logic [MS_W-1:0]    REFRACTORY_RST     = 16'd400;
    localparam logic [MS_W-1:0]    MIN_INTERVAL_RST   = 16'd400;
    localparam logic [MS_W-1:0]    MAX_INTERVAL_RST   = 16'd1500;
    localparam logic [MS_W-1:0]    MAX_JUMP_RST       = 16'd350;
    localparam logic [MS_W-1:0]    SETTLE_RST         = 16'd800;
    localparam logic [MS_W-1:0]    LOW_PERFUSION_RST  = 16'd2500;
    localparam logic [LEVEL_W-1:0] MIN_THR_OFFSET_RST = 18'd12;

    localparam int                  BASELINE_RST_W = 14;
    localparam logic [13:0]         BASELINE_RST   = 14'd15000;
    localparam int                  PROMINENCE     = 10;
    localparam int                  WEAK_AMPLITUDE = 10;
    localparam logic [STREAK_W-1:0] STREAK_MAX     = 2'd3;
    localparam logic [COUNT_W-1:0]  COUNT_MAX      = 4'd10;
    localparam logic [FALL_W-1:0]   FALL_MAX       = 2'd3;
    localparam logic [FALL_W-1:0]   FALL_TRIGGER   = 2'd2;

endpackage

### src/ppg_adaptive_peak_detector.sv
// PPG adaptive peak detector. Each input transaction carries one optical sample
// (IR, red, millisecond time stamp); each produces exactly one result transaction
// with contact, beat flag, beat interval, windowed IR peak-to-peak amplitude,
// contact quality and the saturating beat count. The block takes one sample per
// clock cycle: a sample is first captured in the input register, then the whole
// detector update runs in a single combinational pass into the result register,
// whose valid flag drives m_axis_tvalid once the master side lets it advance.
// Only a stalled master side slows the stream. With the result register full and
// the master side stalled, one more sample is held in the input register.
// Thresholds and timing limits are set over the APB port
// (register i at byte address 4*i) and should only be written while no sample
// is in flight. Losing contact clears the window, the beat history and the count.
module ppg_adaptive_peak_detector #(
    parameter int SAMPLE_BITS = 18,
    parameter int WINDOW_LEN  = 50,
    parameter int TIME_BITS   = 32,
    localparam int IN_W  = ((2 * SAMPLE_BITS + TIME_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((SAMPLE_BITS + 24 + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppg_apd_pkg::ADDR_W-1:0] paddr,
    input  logic [ppg_apd_pkg::DATA_W-1:0] pwdata,
    output logic [ppg_apd_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    // sample stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,   // ir_sample, red_sample, time_ms
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // contact, beat, interval_ms, amplitude, quality, beat_total
    output logic [OUT_W-1:0]              m_axis_tdata
);

    localparam int SB      = SAMPLE_BITS;
    localparam int TB      = TIME_BITS;
    localparam int MS_W    = ppg_apd_pkg::MS_W;
    localparam int LEVEL_W = ppg_apd_pkg::LEVEL_W;
    localparam int CNT_W   = ppg_apd_pkg::COUNT_W;
    localparam int STK_W   = ppg_apd_pkg::STREAK_W;
    localparam int FALL_W  = ppg_apd_pkg::FALL_W;
    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int BASE_W  = (SB > ppg_apd_pkg::BASELINE_RST_W) ? SB
                                                               : ppg_apd_pkg::BASELINE_RST_W;
    localparam int SUM_W   = BASE_W + 6;
    localparam int CMP_W   = (SB > LEVEL_W) ? SB : LEVEL_W;

    // ---------------- configuration registers ----------------
    logic [LEVEL_W-1:0] r_contact_level, r_min_thr_offset;
    logic [MS_W-1:0]    r_refractory_ms, r_min_interval_ms, r_max_interval_ms;
    logic [MS_W-1:0]    r_max_jump_ms, r_settle_ms, r_low_perfusion_ms;

    ppg_apd_pkg::t_reg_idx cfg_idx;
    logic                  cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = ppg_apd_pkg::t_reg_idx'(paddr[ppg_apd_pkg::ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_contact_level    <= ppg_apd_pkg::CONTACT_LEVEL_RST;
            r_refractory_ms    <= ppg_apd_pkg::REFRACTORY_RST;
            r_min_interval_ms  <= ppg_apd_pkg::MIN_INTERVAL_RST;
            r_max_interval_ms  <= ppg_apd_pkg::MAX_INTERVAL_RST;
            r_max_jump_ms      <= ppg_apd_pkg::MAX_JUMP_RST;
            r_settle_ms        <= ppg_apd_pkg::SETTLE_RST;
            r_low_perfusion_ms <= ppg_apd_pkg::LOW_PERFUSION_RST;
            r_min_thr_offset   <= ppg_apd_pkg::MIN_THR_OFFSET_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ppg_apd_pkg::REG_CONTACT_LEVEL:    r_contact_level    <= pwdata[LEVEL_W-1:0];
                ppg_apd_pkg::REG_REFRACTORY_MS:    r_refractory_ms    <= pwdata[MS_W-1:0];
                ppg_apd_pkg::REG_MIN_INTERVAL_MS:  r_min_interval_ms  <= pwdata[MS_W-1:0];
                ppg_apd_pkg::REG_MAX_INTERVAL_MS:  r_max_interval_ms  <= pwdata[MS_W-1:0];
                ppg_apd_pkg::REG_MAX_JUMP_MS:      r_max_jump_ms      <= pwdata[MS_W-1:0];
                ppg_apd_pkg::REG_SETTLE_MS:        r_settle_ms        <= pwdata[MS_W-1:0];
                ppg_apd_pkg::REG_LOW_PERFUSION_MS: r_low_perfusion_ms <= pwdata[MS_W-1:0];
                ppg_apd_pkg::REG_MIN_THR_OFFSET:   r_min_thr_offset   <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            ppg_apd_pkg::REG_CONTACT_LEVEL:    prdata = 32'(r_contact_level);
            ppg_apd_pkg::REG_REFRACTORY_MS:    prdata = 32'(r_refractory_ms);
            ppg_apd_pkg::REG_MIN_INTERVAL_MS:  prdata = 32'(r_min_interval_ms);
            ppg_apd_pkg::REG_MAX_INTERVAL_MS:  prdata = 32'(r_max_interval_ms);
            ppg_apd_pkg::REG_MAX_JUMP_MS:      prdata = 32'(r_max_jump_ms);
            ppg_apd_pkg::REG_SETTLE_MS:        prdata = 32'(r_settle_ms);
            ppg_apd_pkg::REG_LOW_PERFUSION_MS: prdata = 32'(r_low_perfusion_ms);
            ppg_apd_pkg::REG_MIN_THR_OFFSET:   prdata = 32'(r_min_thr_offset);
            default:                           prdata = '0;
        endcase
    end

    // ---------------- stream handshake ----------------
    logic          r_in_valid, r_out_valid;
    logic [SB-1:0] r_in_ir, r_in_red;
    logic [TB-1:0] r_in_time;
    logic          advance, proc;

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;
    assign proc          = r_in_valid && advance;
    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // input payload register
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ir   <= s_axis_tdata[SB-1:0];
            r_in_red  <= s_axis_tdata[2*SB-1:SB];
            r_in_time <= s_axis_tdata[2*SB+TB-1:2*SB];
        end
    end

    // ---------------- detector state ----------------
    ppg_apd_pkg::t_phase r_phase, n_phase;
    logic [SB-1:0]     r_prev_ir, n_prev_ir;
    logic [SB-1:0]     r_crest, n_crest;
    logic [FALL_W-1:0] r_fall_run, n_fall_run;
    logic [TB-1:0]     r_blank_until, n_blank_until;
    logic [TB-1:0]     r_last_crest, n_last_crest;
    logic [MS_W-1:0]   r_last_good, n_last_good;
    logic [STK_W-1:0]  r_good_streak, n_good_streak;
    logic [TB-1:0]     r_contact_start, n_contact_start;
    logic              r_contact_valid, n_contact_valid;
    logic [BASE_W-1:0] r_baseline, n_baseline;
    logic [SB-1:0]     r_window_low, n_window_low;
    logic [SB-1:0]     r_window_high, n_window_high;
    logic [FILL_W-1:0] r_window_fill, n_window_fill;
    logic [SB-1:0]     r_last_amp, n_last_amp;
    logic [CNT_W-1:0]  r_count, n_count;

    // result register payload
    logic            r_out_contact, r_out_beat;
    logic [MS_W-1:0] r_out_interval;
    logic [SB-1:0]   r_out_amp;
    logic [1:0]      r_out_quality;
    logic [CNT_W-1:0] r_out_count;
    logic            n_beat;
    logic [MS_W-1:0] n_interval;
    ppg_apd_pkg::t_quality n_quality;

    // intermediate values
    logic              contact;
    logic [SB-1:0]     win_low, win_high;
    logic [FILL_W-1:0] fill_inc;
    logic [SUM_W-1:0]  base_x, base_sum;
    logic [SB-1:0]     base_new;
    logic [CMP_W-1:0]  amp_quarter, thr_floor, offset;
    logic [CMP_W:0]    threshold;
    logic [SB:0]       crest_floor;
    logic [TB-1:0]     elapsed, ibi, ibi_diff, lgi_x;
    logic [FALL_W-1:0] fall_inc;

    always_comb begin
        // defaults: hold
        n_phase         = r_phase;
        n_prev_ir       = r_prev_ir;
        n_crest         = r_crest;
        n_fall_run      = r_fall_run;
        n_blank_until   = r_blank_until;
        n_last_crest    = r_last_crest;
        n_last_good     = r_last_good;
        n_good_streak   = r_good_streak;
        n_contact_start = r_contact_start;
        n_contact_valid = r_contact_valid;
        n_baseline      = r_baseline;
        n_count         = r_count;
        n_beat          = 1'b0;
        n_interval      = '0;
        n_quality       = ppg_apd_pkg::Q_NO_CONTACT;

        // amplitude window
        win_low       = (r_in_ir < r_window_low) ? r_in_ir : r_window_low;
        win_high      = (r_in_ir > r_window_high) ? r_in_ir : r_window_high;
        fill_inc      = r_window_fill + 1'b1;
        n_window_low  = win_low;
        n_window_high = win_high;
        n_window_fill = fill_inc;
        n_last_amp    = r_last_amp;
        if (fill_inc >= FILL_W'(WINDOW_LEN)) begin
            n_last_amp    = (win_high > win_low) ? (win_high - win_low) : '0;
            n_window_low  = '1;
            n_window_high = '0;
            n_window_fill = '0;
        end

        contact = (CMP_W'(r_in_ir) > CMP_W'(r_contact_level)) ||
                  (CMP_W'(r_in_red) > CMP_W'(r_contact_level));

        // baseline: (b*31 + ir) / 32
        base_x      = SUM_W'(r_baseline);
        base_sum    = (base_x << 5) - base_x + SUM_W'(r_in_ir);
        base_new    = base_sum[SB+4:5];

        // adaptive threshold
        amp_quarter = CMP_W'(n_last_amp >> 2);
        thr_floor   = CMP_W'(r_min_thr_offset);
        offset      = (amp_quarter < thr_floor) ? thr_floor : amp_quarter;
        threshold   = (CMP_W+1)'(base_new) + (CMP_W+1)'(offset);
        crest_floor = (SB+1)'(base_new) + (SB+1)'(ppg_apd_pkg::PROMINENCE);

        n_contact_start = r_contact_valid ? r_contact_start : r_in_time;
        elapsed  = r_in_time - n_contact_start;
        ibi      = r_in_time - r_last_crest;
        lgi_x    = TB'(r_last_good);
        ibi_diff = (ibi > lgi_x) ? (ibi - lgi_x) : (lgi_x - ibi);
        fall_inc = (r_fall_run != ppg_apd_pkg::FALL_MAX) ? (r_fall_run + 1'b1) : r_fall_run;

        if (contact) begin
            n_contact_valid = 1'b1;
            n_baseline      = BASE_W'(base_new);

            // crest detector
            unique case (r_phase)
                ppg_apd_pkg::PH_RISING: begin
                    if (r_in_ir > r_crest) begin
                        n_crest = r_in_ir;
                    end
                    if (r_in_ir < r_prev_ir) begin
                        n_fall_run = fall_inc;
                        if (fall_inc >= ppg_apd_pkg::FALL_TRIGGER) begin
                            if ((SB+1)'(n_crest) > crest_floor) begin
                                // accept crest and check the interval
                                n_last_crest  = r_in_time;
                                n_phase       = ppg_apd_pkg::PH_BLANK;
                                n_blank_until = r_in_time + TB'(r_refractory_ms);
                                if ((elapsed > TB'(r_settle_ms)) &&
                                    (ibi >= TB'(r_min_interval_ms)) &&
                                    (ibi <= TB'(r_max_interval_ms)) &&
                                    ((r_last_good == '0) ||
                                     (ibi_diff <= TB'(r_max_jump_ms)))) begin
                                    n_last_good = ibi[MS_W-1:0];
                                    n_interval  = ibi[MS_W-1:0];
                                    n_beat      = 1'b1;
                                    if (r_good_streak < ppg_apd_pkg::STREAK_MAX) begin
                                        n_good_streak = r_good_streak + 1'b1;
                                    end
                                    if (r_count < ppg_apd_pkg::COUNT_MAX) begin
                                        n_count = r_count + 1'b1;
                                    end
                                end
                            end else begin
                                n_phase = ppg_apd_pkg::PH_ARMED;
                            end
                        end
                    end else begin
                        n_fall_run = '0;
                    end
                end
                ppg_apd_pkg::PH_BLANK: begin
                    if (r_in_time >= r_blank_until) begin
                        n_phase = ppg_apd_pkg::PH_ARMED;
                    end
                end
                default: begin
                    if ((CMP_W+1)'(r_in_ir) >= threshold) begin
                        n_phase    = ppg_apd_pkg::PH_RISING;
                        n_crest    = r_in_ir;
                        n_fall_run = '0;
                    end
                end
            endcase
            n_prev_ir = r_in_ir;

            // contact quality
            if ((elapsed > TB'(r_low_perfusion_ms)) &&
                ((n_last_amp < SB'(ppg_apd_pkg::WEAK_AMPLITUDE)) || (n_good_streak == '0))) begin
                n_quality = ppg_apd_pkg::Q_LOW_PERFUSION;
            end else if (n_count < ppg_apd_pkg::COUNT_MAX) begin
                n_quality = ppg_apd_pkg::Q_ACQUIRING;
            end else begin
                n_quality = ppg_apd_pkg::Q_TRACKING;
            end
        end else begin
            // contact lost: drop tracking state
            n_contact_valid = 1'b0;
            n_contact_start = '0;
            n_last_crest    = '0;
            n_last_good     = '0;
            n_good_streak   = '0;
            n_crest         = '0;
            n_fall_run      = '0;
            n_phase         = ppg_apd_pkg::PH_ARMED;
            n_last_amp      = '0;
            n_window_low    = '1;
            n_window_high   = '0;
            n_window_fill   = '0;
            n_count         = '0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ppg_apd_pkg::PH_ARMED;
            r_prev_ir       <= '0;
            r_crest         <= '0;
            r_fall_run      <= '0;
            r_blank_until   <= '0;
            r_last_crest    <= '0;
            r_last_good     <= '0;
            r_good_streak   <= '0;
            r_contact_start <= '0;
            r_contact_valid <= 1'b0;
            r_baseline      <= BASE_W'(ppg_apd_pkg::BASELINE_RST);
            r_window_low    <= '1;
            r_window_high   <= '0;
            r_window_fill   <= '0;
            r_last_amp      <= '0;
            r_count         <= '0;
        end else if (proc) begin
            r_phase         <= n_phase;
            r_prev_ir       <= n_prev_ir;
            r_crest         <= n_crest;
            r_fall_run      <= n_fall_run;
            r_blank_until   <= n_blank_until;
            r_last_crest    <= n_last_crest;
            r_last_good     <= n_last_good;
            r_good_streak   <= n_good_streak;
            r_contact_start <= n_contact_start;
            r_contact_valid <= n_contact_valid;
            r_baseline      <= n_baseline;
            r_window_low    <= n_window_low;
            r_window_high   <= n_window_high;
            r_window_fill   <= n_window_fill;
            r_last_amp      <= n_last_amp;
            r_count         <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_contact  <= contact;
            r_out_beat     <= n_beat;
            r_out_interval <= n_interval;
            r_out_amp      <= n_last_amp;
            r_out_quality  <= n_quality;
            r_out_count    <= n_count;
        end
    end

    assign m_axis_tdata = OUT_W'({r_out_count, r_out_quality, r_out_amp,
                                  r_out_interval, r_out_beat, r_out_contact});

`ifndef SYNTHESIS
    // a beat is only reported in contact, inside the interval range, and counted
    a_beat_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_beat) |->
            (r_out_contact && (r_out_interval >= r_min_interval_ms) &&
             (r_out_interval <= r_max_interval_ms) && (r_out_count != '0)))
        else $error("beat result outside interval range or without contact");

    // beat count only exists while contact is tracked
    a_count_needs_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_contact_valid |-> ((r_count == '0) && (r_good_streak == '0)))
        else $error("beat history kept without contact");

    // an empty window has its extremes cleared
    a_window_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_window_fill == '0) |-> ((r_window_high == '0) && (&r_window_low)))
        else $error("window extremes not cleared at window start");

    // refractory phase only follows an accepted crest during contact
    a_blank_in_contact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ppg_apd_pkg::PH_BLANK) |-> r_contact_valid)
        else $error("refractory phase without contact");

    // a processed sample always lands in the result register
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed sample produced no result");
`endif

endmodule
